// ----- rtl/core/lppt_pkg.sv -----
`timescale 1ns / 1ps

package lppt_pkg;

  // field widths
  localparam int TIME_W  = 32;
  localparam int DELTA_W = 24;
  localparam int RATE_W  = 16;
  localparam int SPAN_W  = 16;
  localparam int MODE_W  = 3;
  localparam int IDX_W   = 3;

  // command codes
  localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PLAY  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PAUSE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STOP  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SEEK  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_END   = 3'd5;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_SEQ_LEN   = 3'd0;
  localparam logic [IDX_W-1:0] REG_START_REQ = 3'd1;
  localparam logic [IDX_W-1:0] REG_END_REQ   = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN_SPAN  = 3'd3;
  localparam logic [IDX_W-1:0] REG_PLAY_RATE = 3'd4;
  localparam logic [IDX_W-1:0] REG_LOOPING   = 3'd5;

  typedef logic [TIME_W-1:0] time_t;

  // clamp a time value into [lo, hi]
  function automatic time_t clamp_time(time_t v, time_t lo, time_t hi);
    time_t r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// ----- rtl/core/looping_playback_position_timer.sv -----
`timescale 1ns / 1ps
// Commands and ticks while paused pass EXEC and DONE on the way to out_valid; a clamping tick
// passes EXEC, MUL, SUM, CLAMP and DONE; a looping tick passes EXEC, MUL, SUM, OFF, ABS, the
// remainder loop REM that retires one bit of the offset per cycle, FIX, ADD and DONE.
// One item in flight; a new one can be taken once its result is loaded, unless a configuration write stalls.
// A range register write holds in_stall high until the range has passed the renormalisation pipeline.
// Reset (rst, synchronous): position 0, paused, no pose pending, registers to defaults.
module looping_playback_position_timer #(
  parameter int RATE_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          wr_en,
  input  logic [lppt_pkg::IDX_W-1:0]    wr_index,
  input  logic [lppt_pkg::TIME_W-1:0]   wr_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lppt_pkg::MODE_W-1:0]   mode,
  input  logic [lppt_pkg::DELTA_W-1:0]  delta_time,
  input  logic [lppt_pkg::TIME_W-1:0]   seek_time,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lppt_pkg::TIME_W-1:0]   position,
  output logic                          is_playing,
  output logic                          wrapped,
  output logic                          pose_pending
);

  localparam int TW      = lppt_pkg::TIME_W;
  localparam int PROD_W  = lppt_pkg::DELTA_W + lppt_pkg::RATE_W;
  localparam int STEP_W  = PROD_W - RATE_FRAC_BITS;
  localparam int SUM_W   = ((STEP_W > TW) ? STEP_W : TW) + 2;
  localparam int MAG_W   = SUM_W - 1;
  localparam int CNT_W   = $clog2(MAG_W + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_EXEC  = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_SUM   = 4'd3;
  localparam logic [3:0] ST_OFF   = 4'd4;
  localparam logic [3:0] ST_ABS   = 4'd5;
  localparam logic [3:0] ST_REM   = 4'd6;
  localparam logic [3:0] ST_FIX   = 4'd7;
  localparam logic [3:0] ST_ADD   = 4'd8;
  localparam logic [3:0] ST_CLAMP = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  // configuration registers
  logic [TW-1:0]                   seq_len;
  logic [TW-1:0]                   start_req;
  logic [TW-1:0]                   end_req;
  logic [lppt_pkg::SPAN_W-1:0]     min_span;
  logic [lppt_pkg::RATE_W-1:0]     play_rate;
  logic                            looping;

  // effective range, cached after each renormalisation
  logic [TW-1:0] rs;
  logic [TW-1:0] re;
  logic [TW-1:0] rlen;

  // block state
  logic [TW-1:0] pos_reg;
  logic          playing;
  logic          dirty;
  logic          wrap_q;

  // range normalisation pipeline
  logic          trig;
  logic          v1, v2, v3, v4, v5;
  logic          lz1, lz2, lz3, lz4, lz5;
  logic [TW-1:0] s0_1, e0_1, len_1;
  logic [lppt_pkg::SPAN_W-1:0] span_1, span_2, span_3;
  logic [TW-1:0] s1_2, e0_2, len_2;
  logic [TW:0]   t_3, e1_3;
  logic [TW-1:0] s1_3, len_3;
  logic [TW-1:0] e2_4, tl_4, s1_4;
  logic [TW:0]   t_4;
  logic [lppt_pkg::SPAN_W-1:0] span_4;
  logic [TW-1:0] rs_n, re_n;
  logic          cfg_busy;

  // item sequencer
  logic [3:0]                     st;
  logic [lppt_pkg::MODE_W-1:0]    mode_q;
  logic [lppt_pkg::DELTA_W-1:0]   delta_q;
  logic [TW-1:0]                  seek_q;
  logic [PROD_W-1:0]              prod;
  logic signed [SUM_W-1:0]        sum_v;
  logic [SUM_W-1:0]               off_v;
  logic                           off_neg;
  logic [MAG_W-1:0]               mag;
  logic [TW-1:0]                  rem;
  logic [CNT_W-1:0]               cnt;
  logic [TW-1:0]                  radj;

  // combinational helpers
  logic                           rate_neg;
  logic [lppt_pkg::RATE_W-1:0]    rate_mag;
  logic [STEP_W-1:0]              step;
  logic signed [SUM_W-1:0]        pos_s, step_s, rs_s, re_s;
  logic [SUM_W-1:0]               off_abs;
  logic [TW:0]                    rem_sh;
  logic [TW:0]                    rem_diff;
  logic [TW-1:0]                  np;
  logic                           in_take;
  logic                           out_free;

  assign cfg_busy = trig | v1 | v2 | v3 | v4 | v5;
  assign in_stall = (st != ST_IDLE) | cfg_busy | wr_en;
  assign in_take  = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;

  assign rate_neg = play_rate[lppt_pkg::RATE_W-1];
  assign rate_mag = rate_neg ? (lppt_pkg::RATE_W'(0) - play_rate) : play_rate;
  assign step     = prod[PROD_W-1:RATE_FRAC_BITS];
  assign pos_s    = $signed(SUM_W'(pos_reg));
  assign step_s   = $signed(SUM_W'(step));
  assign rs_s     = $signed(SUM_W'(rs));
  assign re_s     = $signed(SUM_W'(re));
  assign off_abs  = off_v[SUM_W-1] ? (SUM_W'(0) - off_v) : off_v;
  assign rem_sh   = {rem, mag[MAG_W-1]};
  assign rem_diff = rem_sh - {1'b0, rlen};
  assign np       = rs + radj;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len   <= '0;
      start_req <= '0;
      end_req   <= '1;
      min_span  <= lppt_pkg::SPAN_W'(273);
      play_rate <= lppt_pkg::RATE_W'(256);
      looping   <= 1'b1;
      trig      <= 1'b0;
    end else begin
      trig <= 1'b0;
      if (wr_en) begin
        case (wr_index)
          lppt_pkg::REG_SEQ_LEN: begin
            seq_len <= wr_data;
            trig    <= 1'b1;
          end
          lppt_pkg::REG_START_REQ: begin
            start_req <= wr_data;
            trig      <= 1'b1;
          end
          lppt_pkg::REG_END_REQ: begin
            end_req <= wr_data;
            trig    <= 1'b1;
          end
          lppt_pkg::REG_MIN_SPAN: begin
            min_span <= wr_data[lppt_pkg::SPAN_W-1:0];
            trig     <= 1'b1;
          end
          lppt_pkg::REG_PLAY_RATE: play_rate <= wr_data[lppt_pkg::RATE_W-1:0];
          lppt_pkg::REG_LOOPING:   looping   <= wr_data[0];
          default: ;
        endcase
      end
    end
  end

  // normalisation pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= trig;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // normalisation pipeline payload: order, clamp to length, widen to min span
  always_ff @(posedge clk) begin
    // order start and end
    s0_1   <= (start_req < end_req) ? start_req : end_req;
    e0_1   <= (start_req < end_req) ? end_req : start_req;
    len_1  <= seq_len;
    span_1 <= min_span;
    lz1    <= (seq_len == '0);
    // start no later than the length
    s1_2   <= (s0_1 > len_1) ? len_1 : s0_1;
    e0_2   <= e0_1;
    len_2  <= len_1;
    span_2 <= span_1;
    lz2    <= lz1;
    // end at least start plus span
    t_3    <= {1'b0, s1_2} + (TW+1)'(span_2);
    e1_3   <= (({1'b0, e0_2} < ({1'b0, s1_2} + (TW+1)'(span_2))) ?
               ({1'b0, s1_2} + (TW+1)'(span_2)) : {1'b0, e0_2});
    s1_3   <= s1_2;
    len_3  <= len_2;
    span_3 <= span_2;
    lz3    <= lz2;
    // end no later than the length
    e2_4   <= (e1_3 > {1'b0, len_3}) ? len_3 : e1_3[TW-1:0];
    tl_4   <= (t_3 < {1'b0, len_3}) ? t_3[TW-1:0] : len_3;
    t_4    <= t_3;
    s1_4   <= s1_3;
    span_4 <= span_3;
    lz4    <= lz3;
    // zero length gives an empty range; span too short after clamping: pull the start back
    if (lz4) begin
      rs_n <= '0;
      re_n <= '0;
    end else if ({1'b0, e2_4} < t_4) begin
      re_n <= tl_4;
      rs_n <= (tl_4 > TW'(span_4)) ? (tl_4 - TW'(span_4)) : '0;
    end else begin
      re_n <= e2_4;
      rs_n <= s1_4;
    end
    lz5 <= lz4;
  end

  // item sequencer, remainder loop, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      pos_reg   <= '0;
      playing   <= 1'b0;
      dirty     <= 1'b0;
      rs        <= '0;
      re        <= '0;
      rlen      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;

      case (st)
        ST_IDLE: begin
          if (in_take) begin
            mode_q  <= mode;
            delta_q <= delta_time;
            seek_q  <= seek_time;
            st      <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          wrap_q <= 1'b0;
          st     <= ST_DONE;
          case (mode_q)
            lppt_pkg::MODE_TICK: begin
              if (dirty) begin
                pos_reg <= lppt_pkg::clamp_time(pos_reg, rs, re);
                dirty   <= 1'b0;
              end
              if (playing) st <= ST_MUL;
            end
            lppt_pkg::MODE_PLAY:  playing <= (seq_len != '0);
            lppt_pkg::MODE_PAUSE: playing <= 1'b0;
            lppt_pkg::MODE_STOP: begin
              playing <= 1'b0;
              pos_reg <= rs;
              dirty   <= 1'b1;
            end
            lppt_pkg::MODE_SEEK: begin
              pos_reg <= lppt_pkg::clamp_time(seek_q, rs, re);
              dirty   <= 1'b1;
            end
            lppt_pkg::MODE_END: begin
              playing <= 1'b0;
              pos_reg <= re;
              dirty   <= 1'b1;
            end
            default: ;
          endcase
        end
        ST_MUL: begin
          prod <= PROD_W'(delta_q) * PROD_W'(rate_mag);
          st   <= ST_SUM;
        end
        ST_SUM: begin
          sum_v <= rate_neg ? (pos_s - step_s) : (pos_s + step_s);
          st    <= (looping && rlen != '0) ? ST_OFF : ST_CLAMP;
        end
        ST_OFF: begin
          off_v <= SUM_W'(sum_v - rs_s);
          st    <= ST_ABS;
        end
        ST_ABS: begin
          off_neg <= off_v[SUM_W-1];
          mag     <= off_abs[MAG_W-1:0];
          rem     <= '0;
          cnt     <= CNT_W'(MAG_W);
          st      <= ST_REM;
        end
        // restoring remainder, one offset bit per cycle
        ST_REM: begin
          rem <= rem_diff[TW] ? rem_sh[TW-1:0] : rem_diff[TW-1:0];
          mag <= {mag[MAG_W-2:0], 1'b0};
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) st <= ST_FIX;
        end
        // floored modulo for negative offsets
        ST_FIX: begin
          radj <= (off_neg && rem != '0) ? (rlen - rem) : rem;
          st   <= ST_ADD;
        end
        ST_ADD: begin
          wrap_q  <= rate_neg ? (np > pos_reg) : (np < pos_reg);
          pos_reg <= np;
          st      <= ST_DONE;
        end
        ST_CLAMP: begin
          if (sum_v < rs_s) pos_reg <= rs;
          else if (sum_v > re_s) pos_reg <= re;
          else pos_reg <= sum_v[TW-1:0];
          if ((!rate_neg && sum_v >= re_s) || (rate_neg && sum_v <= rs_s)) playing <= 1'b0;
          st <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            position     <= pos_reg;
            is_playing   <= playing;
            wrapped      <= wrap_q;
            pose_pending <= dirty;
            out_valid    <= 1'b1;
            st           <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase

      // new range takes effect: reclamp the position and mark it pending
      if (v5) begin
        rs      <= rs_n;
        re      <= re_n;
        rlen    <= re_n - rs_n;
        pos_reg <= lz5 ? '0 : lppt_pkg::clamp_time(pos_reg, rs_n, re_n);
        dirty   <= 1'b1;
      end
    end
  end

`ifndef SYNTH
  // the cached range is always ordered
  assert property (@(posedge clk) disable iff (rst) rs <= re)
    else $error("effective range start above its end");

  // the partial remainder stays below the range length while iterating
  assert property (@(posedge clk) disable iff (rst) (st == ST_REM) |-> (rem < rlen))
    else $error("remainder escaped the range length");

  // a finished item with a free output slot is presented next cycle
  assert property (@(posedge clk) disable iff (rst)
    (st == ST_DONE && out_free) |=> (out_valid && st == ST_IDLE))
    else $error("result not loaded into the output register");

  // after a range update the position sits inside the new range
  assert property (@(posedge clk) disable iff (rst)
    (v5 && !lz5 && st == ST_IDLE) |=> (pos_reg >= rs && pos_reg <= re))
    else $error("position outside the range after renormalisation");
`endif

endmodule
